>>> src/ctsd_pkg.sv
`default_nettype none
package ctsd_pkg;

    localparam int ISQ_STEPS = 31;              // radicand < 2^61, one result bit per step

    localparam logic [29:0] SLOPE_LIMIT = 30'd655360000;   // 10000 in Q.16
    localparam logic [28:0] KAPPA_Q40   = 29'd329625293;
    localparam logic signed [31:0] Z_BZ_END   = 32'sd51200;   // 200 cm, Q.8
    localparam logic signed [31:0] Z_BY_START = 32'sd89600;   // 350 cm
    localparam logic signed [31:0] Z_BY_END   = 32'sd115200;  // 450 cm
    localparam logic [23:0] DEF_BZ = 24'd81920;  // 20 kG, Q.12
    localparam logic [23:0] DEF_BY = 24'd20480;  // 5 kG

    // values that ride alongside the square root pipe
    typedef struct packed {
        logic [63:0] mtx;
        logic        stx;
        logic [63:0] mty;
        logic        sty;
        logic [60:0] mkp;
        logic        skp;
    } side_t;

endpackage
`default_nettype wire

>>> src/charged_track_slope_derivative_unit.sv
// Channel   Dir  Signals                      Item
// s_axis    in   s_tvalid/s_tready/s_tdata    one track step (slopes, q/p, z, field)
// m_axis    out  m_tvalid/m_tready/m_tdata    curvatures, m_tuser = saturated
// cfg       in   cfg_we/cfg_wdata             use_external_field
//
// One item per cycle sustained while the output is not stalled; 6 front
// stages, 31 root stages at one result bit each, 5 back stages.
// Async active-low reset clears valid bits and use_external_field.
// All stages share one enable: a stalled output freezes the whole pipe.
`default_nettype none
module charged_track_slope_derivative_unit
    import ctsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // slope_x[31:0] slope_y[63:32] charge_over_momentum[95:64] z_position[127:96]
    // field_x_kgauss[151:128] field_y_kgauss[175:152] field_z_kgauss[199:176]
    input  wire logic [199:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // curvature_x[63:0] curvature_y[127:64]
    output logic [127:0]      m_tdata,
    // saturated[0]
    output logic              m_tuser
);

    logic use_ext_reg;
    logic en;

    logic        f_valid;
    logic [60:0] f_rad;
    side_t       f_side;
    logic        q_valid;
    logic [29:0] q_root;
    side_t       q_side;
    logic [63:0] cx, cy;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_ext_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            use_ext_reg <= cfg_wdata;
        end
    end

    ctsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .use_ext  (use_ext_reg),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .out_valid(f_valid),
        .out_rad  (f_rad),
        .out_side (f_side)
    );

    ctsd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (f_valid),
        .in_rad   (f_rad),
        .in_side  (f_side),
        .out_valid(q_valid),
        .out_root (q_root),
        .out_side (q_side)
    );

    ctsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (q_valid),
        .in_root  (q_root),
        .in_side  (q_side),
        .out_valid(m_tvalid),
        .out_cx   (cx),
        .out_cy   (cy),
        .out_sat  (m_tuser)
    );

    assign m_tdata = {cy, cx};

    // a held result blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // the flag only comes with a clamped value
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (cx == {1'b0, {63{1'b1}}}) || (cx == {1'b1, 63'd0})
            || (cy == {1'b0, {63{1'b1}}}) || (cy == {1'b1, 63'd0}))
        else $error("saturated set without a limit value");

endmodule
`default_nettype wire

>>> src/ctsd_front.sv
`default_nettype none
module ctsd_front
    import ctsd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         use_ext,
    input  wire logic         in_valid,
    input  wire logic [199:0] in_data,
    output logic              out_valid,
    output logic [60:0]       out_rad,
    output side_t             out_side
);

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [23:0] mag24(input logic [23:0] v);
        mag24 = v[23] ? (24'd0 - v) : v;
    endfunction

    function automatic logic [63:0] apply_sign(input logic [63:0] m, input logic neg);
        apply_sign = neg ? (64'd0 - m) : m;
    endfunction

    logic [5:0] v_reg;

    // ---- stage 1: clamp, field select
    logic [31:0] ax, ay;
    logic signed [31:0] z;
    logic [29:0] mx_next, my_next;
    logic [23:0] mbx_next, mby_next, mbz_next;
    logic sbx_next, sby_next, sbz_next;

    assign ax = mag32(in_data[31:0]);
    assign ay = mag32(in_data[63:32]);
    assign z  = $signed(in_data[127:96]);
    assign mx_next = (ax > {2'b00, SLOPE_LIMIT}) ? SLOPE_LIMIT : ax[29:0];
    assign my_next = (ay > {2'b00, SLOPE_LIMIT}) ? SLOPE_LIMIT : ay[29:0];

    always_comb
    begin
        if (use_ext)
        begin
            mbx_next = mag24(in_data[151:128]);
            mby_next = mag24(in_data[175:152]);
            mbz_next = mag24(in_data[199:176]);
            sbx_next = in_data[151];
            sby_next = in_data[175];
            sbz_next = in_data[199];
        end
        else
        begin
            mbx_next = 24'd0;
            mbz_next = (z > Z_BZ_END) ? 24'd0 : DEF_BZ;
            mby_next = (z > Z_BY_START && z < Z_BY_END) ? DEF_BY : 24'd0;
            sbx_next = 1'b0;
            sby_next = 1'b0;
            sbz_next = 1'b0;
        end
    end

    logic [29:0] mx1_reg, my1_reg;
    logic        sx1_reg, sy1_reg, sq1_reg;
    logic [31:0] mq1_reg;
    logic [23:0] mbx1_reg, mby1_reg, mbz1_reg;
    logic        sbx1_reg, sby1_reg, sbz1_reg;

    // ---- stage 2: squares and cross product of slope magnitudes, q/p * kappa
    logic [59:0] mxx2_reg, myy2_reg, mxy2_reg;
    logic [60:0] mkp2_reg;
    logic [29:0] mx2_reg, my2_reg;
    logic        sx2_reg, sy2_reg, sq2_reg;
    logic [23:0] mbx2_reg, mby2_reg, mbz2_reg;
    logic        sbx2_reg, sby2_reg, sbz2_reg;

    // ---- stage 3: partial products of the field terms, radicand
    logic [28:0] onex_hi, oney_hi;
    assign onex_hi = {1'b0, mxx2_reg[59:32]} + 29'd1;
    assign oney_hi = {1'b0, myy2_reg[59:32]} + 29'd1;

    logic [55:0] p1l_reg, p2l_reg, p4l_reg, p5l_reg;
    logic [51:0] p1h_reg, p5h_reg;
    logic [52:0] p2h_reg, p4h_reg;
    logic [53:0] p3_reg, p6_reg;
    logic [60:0] rad3_reg;
    logic [60:0] mkp3_reg;
    logic        sx3_reg, sy3_reg, sq3_reg, sbx3_reg, sby3_reg, sbz3_reg;

    // ---- stage 4: assemble and shift each term
    logic [84:0] s1, s2, s4, s5;
    assign s1 = (85'(p1h_reg) << 32) + 85'(p1l_reg);
    assign s2 = (85'(p2h_reg) << 32) + 85'(p2l_reg);
    assign s4 = (85'(p4h_reg) << 32) + 85'(p4l_reg);
    assign s5 = (85'(p5h_reg) << 32) + 85'(p5l_reg);

    logic [63:0] mt1_reg, mt2_reg, mt3_reg, mt4_reg, mt5_reg, mt6_reg;
    logic        n1_reg, n2_reg, n3_reg, n4_reg, n5_reg, n6_reg;
    logic [60:0] rad4_reg, mkp4_reg;
    logic        sq4_reg;

    // ---- stage 5: signed sums
    logic [63:0] tx5_reg, ty5_reg;
    logic [60:0] rad5_reg, mkp5_reg;
    logic        sq5_reg;

    // ---- stage 6: magnitudes for the back end
    logic [60:0] rad6_reg;
    side_t       side6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx1_reg  <= mx_next;
            my1_reg  <= my_next;
            sx1_reg  <= in_data[31];
            sy1_reg  <= in_data[63];
            mq1_reg  <= mag32(in_data[95:64]);
            sq1_reg  <= in_data[95];
            mbx1_reg <= mbx_next;
            mby1_reg <= mby_next;
            mbz1_reg <= mbz_next;
            sbx1_reg <= sbx_next;
            sby1_reg <= sby_next;
            sbz1_reg <= sbz_next;

            mxx2_reg <= mx1_reg * mx1_reg;
            myy2_reg <= my1_reg * my1_reg;
            mxy2_reg <= mx1_reg * my1_reg;
            mkp2_reg <= mq1_reg * KAPPA_Q40;
            mx2_reg  <= mx1_reg;
            my2_reg  <= my1_reg;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            sq2_reg  <= sq1_reg;
            mbx2_reg <= mbx1_reg;
            mby2_reg <= mby1_reg;
            mbz2_reg <= mbz1_reg;
            sbx2_reg <= sbx1_reg;
            sby2_reg <= sby1_reg;
            sbz2_reg <= sbz1_reg;

            p1l_reg  <= mxy2_reg[31:0] * mbx2_reg;
            p1h_reg  <= mxy2_reg[59:32] * mbx2_reg;
            p2l_reg  <= mxx2_reg[31:0] * mby2_reg;
            p2h_reg  <= onex_hi * mby2_reg;
            p4l_reg  <= myy2_reg[31:0] * mbx2_reg;
            p4h_reg  <= oney_hi * mbx2_reg;
            p5l_reg  <= mxy2_reg[31:0] * mby2_reg;
            p5h_reg  <= mxy2_reg[59:32] * mby2_reg;
            p3_reg   <= my2_reg * mbz2_reg;
            p6_reg   <= mx2_reg * mbz2_reg;
            rad3_reg <= {1'b0, mxx2_reg} + {1'b0, myy2_reg} + 61'h1_0000_0000;
            mkp3_reg <= mkp2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            sq3_reg  <= sq2_reg;
            sbx3_reg <= sbx2_reg;
            sby3_reg <= sby2_reg;
            sbz3_reg <= sbz2_reg;

            // terms truncate toward zero: shift magnitudes, sign later
            mt1_reg  <= s1[83:20];
            mt2_reg  <= s2[83:20];
            mt3_reg  <= {14'd0, p3_reg[53:4]};
            mt4_reg  <= s4[83:20];
            mt5_reg  <= s5[83:20];
            mt6_reg  <= {14'd0, p6_reg[53:4]};
            n1_reg   <= sx3_reg ^ sy3_reg ^ sbx3_reg;
            n2_reg   <= sby3_reg;
            n3_reg   <= sy3_reg ^ sbz3_reg;
            n4_reg   <= sbx3_reg;
            n5_reg   <= sx3_reg ^ sy3_reg ^ sby3_reg;
            n6_reg   <= sx3_reg ^ sbz3_reg;
            rad4_reg <= rad3_reg;
            mkp4_reg <= mkp3_reg;
            sq4_reg  <= sq3_reg;

            tx5_reg  <= apply_sign(mt1_reg, n1_reg) - apply_sign(mt2_reg, n2_reg)
                        + apply_sign(mt3_reg, n3_reg);
            ty5_reg  <= apply_sign(mt4_reg, n4_reg) - apply_sign(mt5_reg, n5_reg)
                        - apply_sign(mt6_reg, n6_reg);
            rad5_reg <= rad4_reg;
            mkp5_reg <= mkp4_reg;
            sq5_reg  <= sq4_reg;

            rad6_reg       <= rad5_reg;
            side6_reg.mtx  <= apply_sign(tx5_reg, tx5_reg[63]);
            side6_reg.stx  <= tx5_reg[63];
            side6_reg.mty  <= apply_sign(ty5_reg, ty5_reg[63]);
            side6_reg.sty  <= ty5_reg[63];
            side6_reg.mkp  <= mkp5_reg;
            side6_reg.skp  <= sq5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign out_rad   = rad6_reg;
    assign out_side  = side6_reg;

endmodule
`default_nettype wire

>>> src/ctsd_isqrt.sv
`default_nettype none
module ctsd_isqrt
    import ctsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [60:0] in_rad,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [29:0]      out_root,
    output side_t            out_side
);

    logic [ISQ_STEPS-1:0] valid_reg;
    logic [60:0]          rem_reg [ISQ_STEPS];
    logic [60:0]          res_reg [ISQ_STEPS];
    side_t                side_reg [ISQ_STEPS];

    for (genvar k = 0; k < ISQ_STEPS; k++)
    begin : g_step
        localparam logic [60:0] BIT = 61'(1) << (60 - 2 * k);
        logic [60:0] rem_in, res_in, trial;
        logic        vld_in;
        side_t       side_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = in_rad;
            assign res_in  = '0;
            assign vld_in  = in_valid;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign vld_in  = valid_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_in;
                if (rem_in >= trial)
                begin
                    rem_reg[k] <= rem_in - trial;
                    res_reg[k] <= (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_reg[k] <= rem_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign out_valid = valid_reg[ISQ_STEPS-1];
    assign out_root  = res_reg[ISQ_STEPS-1][29:0];
    assign out_side  = side_reg[ISQ_STEPS-1];

endmodule
`default_nettype wire

>>> src/ctsd_back.sv
`default_nettype none
module ctsd_back
    import ctsd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [29:0] in_root,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [63:0]      out_cx,
    output logic [63:0]      out_cy,
    output logic             out_sat
);

    localparam logic [63:0] INT64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT64_MIN = {1'b1, 63'd0};

    logic [4:0] v_reg;

    // B1: kp * root partials
    logic [61:0] kl1_reg;
    logic [58:0] kh1_reg;
    side_t       sd1_reg;

    // B2: kd magnitude, Q.24
    logic [90:0] kd_sum;
    assign kd_sum = (91'(kh1_reg) << 32) + 91'(kl1_reg);
    logic [42:0] mkd2_reg;
    side_t       sd2_reg;

    // B3: kd * t partials
    logic [63:0] xa_reg, xb_reg, ya_reg, yb_reg;
    logic [42:0] xc_reg, xd_reg, yc_reg, yd_reg;
    logic        nx3_reg, ny3_reg;

    // B4: full products
    logic [107:0] px4_reg, py4_reg;
    logic         nx4_reg, ny4_reg;

    // B5: shift, saturate, sign
    logic [83:0] mxv, myv;
    logic        satx, saty;
    logic [63:0] cx_next, cy_next;
    assign mxv = px4_reg[107:24];
    assign myv = py4_reg[107:24];

    always_comb
    begin
        if (nx4_reg)
        begin
            satx    = (|mxv[83:64]) || (mxv[63] && (|mxv[62:0]));
            cx_next = satx ? INT64_MIN : (64'd0 - mxv[63:0]);
        end
        else
        begin
            satx    = |mxv[83:63];
            cx_next = satx ? INT64_MAX : mxv[63:0];
        end
        if (ny4_reg)
        begin
            saty    = (|myv[83:64]) || (myv[63] && (|myv[62:0]));
            cy_next = saty ? INT64_MIN : (64'd0 - myv[63:0]);
        end
        else
        begin
            saty    = |myv[83:63];
            cy_next = saty ? INT64_MAX : myv[63:0];
        end
    end

    logic [63:0] cx_reg, cy_reg;
    logic        sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kl1_reg  <= in_side.mkp[31:0] * in_root;
            kh1_reg  <= in_side.mkp[60:32] * in_root;
            sd1_reg  <= in_side;

            mkd2_reg <= kd_sum[90:48];
            sd2_reg  <= sd1_reg;

            xa_reg   <= mkd2_reg[31:0] * sd2_reg.mtx[31:0];
            xb_reg   <= mkd2_reg[31:0] * sd2_reg.mtx[63:32];
            xc_reg   <= mkd2_reg[42:32] * sd2_reg.mtx[31:0];
            xd_reg   <= mkd2_reg[42:32] * sd2_reg.mtx[63:32];
            ya_reg   <= mkd2_reg[31:0] * sd2_reg.mty[31:0];
            yb_reg   <= mkd2_reg[31:0] * sd2_reg.mty[63:32];
            yc_reg   <= mkd2_reg[42:32] * sd2_reg.mty[31:0];
            yd_reg   <= mkd2_reg[42:32] * sd2_reg.mty[63:32];
            nx3_reg  <= sd2_reg.skp ^ sd2_reg.stx;
            ny3_reg  <= sd2_reg.skp ^ sd2_reg.sty;

            px4_reg  <= 108'(xa_reg) + (108'(xb_reg) << 32) + (108'(xc_reg) << 32)
                        + (108'(xd_reg) << 64);
            py4_reg  <= 108'(ya_reg) + (108'(yb_reg) << 32) + (108'(yc_reg) << 32)
                        + (108'(yd_reg) << 64);
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;

            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            sat_reg  <= satx | saty;
        end
    end

    assign out_valid = v_reg[4];
    assign out_cx    = cx_reg;
    assign out_cy    = cy_reg;
    assign out_sat   = sat_reg;

endmodule
`default_nettype wire
